[rtl/ppse_pkg.sv]
// Shared types, codes and constants of the PCM to PWM sample engine.
package ppse_pkg;

   localparam int FIFO_DEPTH = 8192;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int LEVEL_W    = 13;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_PUSH   = 3'd1;
   localparam logic [2:0] OP_FINISH = 3'd2;
   localparam logic [2:0] OP_START  = 3'd3;
   localparam logic [2:0] OP_STOP   = 3'd4;
   localparam logic [2:0] OP_NONE   = 3'd5;

   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_STREAM = 2'd1;
   localparam logic [1:0] MODE_TONE   = 2'd2;

   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_MODE   = 3'd1;
   localparam logic [2:0] REG_VOLUME = 3'd2;
   localparam logic [2:0] REG_GAIN   = 3'd3;
   localparam logic [2:0] REG_PERIOD = 3'd4;
   localparam logic [2:0] REG_STEP   = 3'd5;

   localparam logic [10:0] GAIN_MAX   = 11'd1024;
   localparam logic [7:0]  MID_LEVEL  = 8'd128;
   localparam logic [7:0]  FULL_LEVEL = 8'd255;
   // floor(2**25 / 255): a quotient estimate that is exact or one short.
   localparam logic [17:0] RECIP_255  = 18'd131586;
   localparam int          RECIP_SH   = 25;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] sample;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic        enable;
      logic [1:0]  mode;
      logic [7:0]  volume;
      logic [10:0] gain;
      logic [16:0] period;
      logic [31:0] step;
   } cfg_type;

   typedef struct packed {
      logic              compare_write;
      logic [15:0]       compare_value;
      logic              underrun;
      logic              drained;
      logic              push_accepted;
      logic [LEVEL_W-1:0] fifo_level;
      logic              armed;
   } rsp_type;

endpackage

[rtl/ppse_front.sv]
// Input side: takes request transfers and classifies them into commands.
module ppse_front import ppse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic [2:0] req_tuser,
   input  logic       req_tlast,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd_data
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff, hold_in;
   cmd_type decoded;

   always_comb begin
      decoded.sample = req_tdata;
      decoded.last   = 1'b0;
      case (req_tuser)
         OP_TICK:   decoded.op = OP_TICK;
         OP_PUSH: begin
            decoded.op   = OP_PUSH;
            decoded.last = req_tlast;
         end
         OP_FINISH: decoded.op = OP_FINISH;
         OP_START:  decoded.op = OP_START;
         OP_STOP:   decoded.op = OP_STOP;
         default:   decoded.op = OP_NONE;
      endcase
   end

   assign req_tready = !hold_valid_ff || cmd_ready;
   assign cmd_valid  = hold_valid_ff;
   assign cmd_data   = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (cmd_ready) begin
         hold_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         hold_valid_in = 1'b1;
         hold_in       = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

[rtl/ppse_cmdq.sv]
// Two-entry command queue between the front and the back.
module ppse_cmdq import ppse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_data,
   output logic    out_valid,
   input  logic    out_pop,
   output cmd_type out_data
);

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rd_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_pop && out_valid;

   always_comb begin
      wr_in    = do_push ? !wr_ff : wr_ff;
      rd_in    = do_pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

endmodule

[rtl/ppse_back.sv]
// Execution side: sample FIFO, playback state, scaling pipeline and result register.
module ppse_back import ppse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cfg_halt,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_GAIN  = 3'd2;
   localparam logic [2:0] ST_MAG   = 3'd3;
   localparam logic [2:0] ST_RECIP = 3'd4;
   localparam logic [2:0] ST_CLAMP = 3'd5;
   localparam logic [2:0] ST_PWM   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W+1)'(FIFO_DEPTH);

   logic [7:0] mem [FIFO_DEPTH];
   logic [7:0] rd_data_ff;

   logic [2:0]       fsm_ff, fsm_in;
   cmd_type          cmd_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             armed_ff, armed_in;
   logic             drain_ff, drain_in;
   logic             chunk_ff, chunk_in;
   logic [31:0]      phase_ff, phase_in;

   logic             mem_we, mem_re;
   logic             cw, und, drn, acc, play, use_mem;
   logic [7:0]       sample;
   logic [PTR_W:0]   used_now, used_next;

   logic             cw_ff, und_ff, drn_ff, acc_ff, play_ff, use_mem_ff, armed_res_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [7:0]       sample_ff;
   logic             neg_ff;
   logic [7:0]       mag_ff;
   logic [17:0]      vg_ff;
   logic [25:0]      x_ff;
   logic [17:0]      y_ff;
   logic [9:0]       q0_ff;
   logic [7:0]       v_ff;
   logic [24:0]      c_ff;

   logic [7:0]       smp;
   logic [35:0]      recip_prod;
   logic [18:0]      q0_x255, rem;
   logic [9:0]       q;
   logic [7:0]       v;
   logic [16:0]      c_sh;

   logic             out_valid_ff;
   rsp_type          out_ff;
   logic             out_load;

   function automatic logic [PTR_W:0] fifo_used(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
      if (wp >= rp) begin
         return {1'b0, wp} - {1'b0, rp};
      end
      return {1'b0, wp} + DEPTH_X - {1'b0, rp};
   endfunction

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign cmd_pop   = (fsm_ff == ST_IDLE) && cmd_valid;
   assign used_now  = fifo_used(wr_ptr_ff, rd_ptr_ff);
   assign used_next = fifo_used(wr_ptr_in, rd_ptr_in);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      armed_in  = armed_ff;
      drain_in  = drain_ff;
      chunk_in  = chunk_ff;
      phase_in  = phase_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      cw        = 1'b0;
      und       = 1'b0;
      drn       = 1'b0;
      acc       = 1'b0;
      play      = 1'b0;
      use_mem   = 1'b0;
      sample    = MID_LEVEL;
      if (fsm_ff == ST_EXEC) begin
         case (cmd_ff.op)
            OP_TICK: begin
               if (cfg.enable && armed_ff &&
                   (cfg.mode == MODE_STREAM || cfg.mode == MODE_TONE)) begin
                  if (cfg.mode == MODE_STREAM) begin
                     if (wr_ptr_ff != rd_ptr_ff) begin
                        mem_re    = 1'b1;
                        use_mem   = 1'b1;
                        rd_ptr_in = ptr_next(rd_ptr_ff);
                        play      = 1'b1;
                     end else if (drain_ff) begin
                        armed_in = 1'b0;
                        cw       = 1'b1;
                        drn      = 1'b1;
                     end else begin
                        und  = 1'b1;
                        play = 1'b1;
                     end
                  end else begin
                     phase_in = phase_ff + cfg.step;
                     sample   = phase_in[31] ? FULL_LEVEL : 8'd0;
                     play     = 1'b1;
                  end
               end
            end
            OP_PUSH: begin
               if (cfg.mode == MODE_STREAM && used_now < DEPTH_X - 1'b1) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = ptr_next(wr_ptr_ff);
                  chunk_in  = 1'b1;
                  acc       = 1'b1;
               end
               if (cmd_ff.last) begin
                  if (chunk_in) begin
                     armed_in = 1'b1;
                  end
                  chunk_in = 1'b0;
               end
            end
            OP_FINISH: drain_in = 1'b1;
            OP_START, OP_STOP: begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
               armed_in  = (cmd_ff.op == OP_START) && cfg.enable && (cfg.mode == MODE_TONE);
               drain_in  = 1'b0;
               chunk_in  = 1'b0;
               phase_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      smp        = use_mem_ff ? rd_data_ff : sample_ff;
      recip_prod = x_ff[25:8] * RECIP_255;
      q0_x255    = {1'b0, q0_ff, 8'd0} - {9'd0, q0_ff};
      rem        = {1'b0, y_ff} - q0_x255;
      q          = q0_ff + {9'd0, (rem >= 19'd255)};
      if (neg_ff) begin
         v = (q >= 10'd128) ? 8'd0 : MID_LEVEL - q[7:0];
      end else begin
         v = (q >= 10'd127) ? FULL_LEVEL : MID_LEVEL + q[7:0];
      end
      c_sh     = c_ff[24:8];
      out_load = (fsm_ff == ST_OUT) && (!out_valid_ff || rsp_ready);
   end

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         ST_IDLE:  fsm_in = cmd_valid ? ST_EXEC : ST_IDLE;
         ST_EXEC:  fsm_in = play ? ST_GAIN : ST_OUT;
         ST_GAIN:  fsm_in = ST_MAG;
         ST_MAG:   fsm_in = ST_RECIP;
         ST_RECIP: fsm_in = ST_CLAMP;
         ST_CLAMP: fsm_in = ST_PWM;
         ST_PWM:   fsm_in = ST_OUT;
         ST_OUT:   fsm_in = out_load ? ST_IDLE : ST_OUT;
         default:  fsm_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= cmd_ff.sample;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_halt) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         armed_ff  <= 1'b0;
         drain_ff  <= 1'b0;
         chunk_ff  <= 1'b0;
         phase_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         armed_ff  <= armed_in;
         drain_ff  <= drain_in;
         chunk_ff  <= chunk_in;
         phase_ff  <= phase_in;
      end
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (fsm_ff == ST_EXEC) begin
         cw_ff        <= cw;
         und_ff       <= und;
         drn_ff       <= drn;
         acc_ff       <= acc;
         play_ff      <= play;
         use_mem_ff   <= use_mem;
         sample_ff    <= sample;
         armed_res_ff <= armed_in;
         level_ff     <= LEVEL_W'(used_next);
      end
      if (fsm_ff == ST_GAIN) begin
         neg_ff <= smp < MID_LEVEL;
         mag_ff <= (smp < MID_LEVEL) ? MID_LEVEL - smp : smp - MID_LEVEL;
         vg_ff  <= {10'd0, cfg.volume} * {7'd0, cfg.gain};
      end
      if (fsm_ff == ST_MAG) begin
         x_ff <= {18'd0, mag_ff} * {8'd0, vg_ff};
      end
      if (fsm_ff == ST_RECIP) begin
         y_ff  <= x_ff[25:8];
         q0_ff <= recip_prod[RECIP_SH+9:RECIP_SH];
      end
      if (fsm_ff == ST_CLAMP) begin
         v_ff <= v;
      end
      if (fsm_ff == ST_PWM) begin
         c_ff <= {17'd0, v_ff} * {8'd0, cfg.period};
      end
      if (out_load) begin
         out_ff.compare_write <= cw_ff || play_ff;
         out_ff.compare_value <= !play_ff ? 16'd0 :
                                 (c_sh[16] ? 16'hFFFF : c_sh[15:0]);
         out_ff.underrun      <= und_ff;
         out_ff.drained       <= drn_ff;
         out_ff.push_accepted <= acc_ff;
         out_ff.fifo_level    <= level_ff;
         out_ff.armed         <= armed_res_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[rtl/pcm_to_pwm_sample_engine_core.sv]
// Top level of the PCM to PWM sample engine: register file and the front, queue and back.
//
//   channel  direction  payload
//   req_     in         tdata: sample_byte; tuser: opcode; tlast: chunk_end
//   rsp_     out        tdata: result fields; tuser: compare_write
//   csr_     in         write enable, register index, write data
//
// A request transfer passes the front's hold register and a command queue slot before the back
// pops it. A command that plays nothing goes through pop, decode and output; on a played tick a
// five-step scaling pipeline follows the FIFO memory read, before the output step, which waits
// while the previous result is not yet taken. The back handles one item at a time.
// Reset is synchronous and active high; the FIFO memory needs no clearing pass.
// A stalled result waits in the output register while the queue keeps taking requests until it is full.
module pcm_to_pwm_sample_engine_core import ppse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // sample_byte
   input  logic [2:0]  req_tuser,   // opcode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // compare_value, underrun, drained, push_accepted, fifo_level, armed, zero fill
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // compare_write
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cfg_halt;
   logic    f_valid, f_ready, q_valid, q_pop;
   cmd_type f_data, q_data;
   logic    b_valid;
   rsp_type b_data;

   always_comb begin
      cfg_in   = cfg_ff;
      cfg_halt = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_ENABLE: begin
               cfg_in.enable = csr_wdata[0];
               cfg_halt      = !csr_wdata[0];
            end
            REG_MODE:   cfg_in.mode   = csr_wdata[1:0];
            REG_VOLUME: cfg_in.volume = csr_wdata[7:0];
            REG_GAIN:   cfg_in.gain   = (csr_wdata[10:0] > GAIN_MAX) ? GAIN_MAX : csr_wdata[10:0];
            REG_PERIOD: cfg_in.period = csr_wdata[16:0];
            REG_STEP:   cfg_in.step   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.mode   <= MODE_OFF;
         cfg_ff.volume <= 8'd0;
         cfg_ff.gain   <= 11'd256;
         cfg_ff.period <= 17'd256;
         cfg_ff.step   <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd_data   (f_data)
   );

   ppse_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_data  (q_data)
   );

   ppse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_halt  (cfg_halt),
      .cmd_valid (q_valid),
      .cmd_pop   (q_pop),
      .cmd_data  (q_data),
      .rsp_valid (b_valid),
      .rsp_ready (rsp_tready),
      .rsp_data  (b_data)
   );

   assign rsp_tvalid = b_valid;
   assign rsp_tuser  = b_data.compare_write;
   assign rsp_tdata  = {7'd0, b_data.armed, b_data.fifo_level, b_data.push_accepted,
                        b_data.drained, b_data.underrun, b_data.compare_value};

endmodule
